/* rtl/core/iiea_pkg.sv */
`default_nettype none

package iiea_pkg;

  // Default number of cells in the row.
  localparam int DEF_CAPACITY = 64;

  localparam int WORD_W = 32;
  localparam int POS_W  = 7;
  localparam int CMD_W  = 3;
  localparam int STAT_W = 2;

  typedef enum logic [CMD_W-1:0] {
    CMD_APPEND = 3'd0,
    CMD_INSERT = 3'd1,
    CMD_ERASE  = 3'd2,
    CMD_CLEAR  = 3'd3,
    CMD_READ   = 3'd4,
    CMD_WRITE  = 3'd5
  } cmd_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } stat_t;

  // Operation broadcast to every cell of the row.
  typedef enum logic [1:0] {
    CELL_HOLD       = 2'd0,
    CELL_SHIFT_UP   = 2'd1,
    CELL_SHIFT_DOWN = 2'd2,
    CELL_WRITE      = 2'd3
  } cell_op_t;

  typedef struct packed {
    cell_op_t            op;
    logic [WORD_W-1:0]   value;
  } cell_ctrl_t;

endpackage

`default_nettype wire

/* rtl/core/iiea_cell.sv */
`default_nettype none

module iiea_cell
  import iiea_pkg::*;
#(
  parameter int IDX = 0,
  parameter int PW  = 7
) (
  input  wire logic              clk,
  input  wire cell_ctrl_t        ctrl,
  input  wire logic [PW-1:0]     op_idx,
  input  wire logic [PW-1:0]     rd_idx,
  input  wire logic [WORD_W-1:0] left_word,
  input  wire logic [WORD_W-1:0] right_word,
  output logic      [WORD_W-1:0] word,
  output logic      [WORD_W-1:0] rd_word
);

  localparam logic [PW-1:0] MY_IDX = PW'(IDX);

  logic [WORD_W-1:0] word_r;
  logic [WORD_W-1:0] word_nxt;

  // An insert moves every cell above the target up by one and loads the target;
  // an erase pulls every cell from the target upward down by one.
  always_comb begin
    word_nxt = word_r;
    unique case (ctrl.op)
      CELL_HOLD: begin
        word_nxt = word_r;
      end
      CELL_SHIFT_UP: begin
        if (MY_IDX > op_idx) begin
          word_nxt = left_word;
        end else if (MY_IDX == op_idx) begin
          word_nxt = ctrl.value;
        end
      end
      CELL_SHIFT_DOWN: begin
        if (MY_IDX >= op_idx) begin
          word_nxt = right_word;
        end
      end
      CELL_WRITE: begin
        if (MY_IDX == op_idx) begin
          word_nxt = ctrl.value;
        end
      end
      default: begin
        word_nxt = word_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    word_r <= word_nxt;
  end

  assign word    = word_r;
  assign rd_word = (MY_IDX == rd_idx) ? word_r : '0;

endmodule

`default_nettype wire

/* rtl/core/indexed_insert_erase_array_core.sv */
`default_nettype none

// Channel   Direction  Transfer when           Contents
// in_*      input      in_tvalid & in_tready   tuser: command; tdata: position, value
// out_*     output     out_tvalid & out_tready tuser: status; tdata: read_value, count
//
// For every command the whole row of cells shifts, loads or holds at the same
// clock edge, so a new command can be taken in every cycle while the output is not stalled.
// A result appears in the output register in the cycle after its command's transfer.
// The input is taken whenever the output register is empty or being drained,
// so a stalled consumer stalls the input only once a result is waiting.
// Reset (rst_n low, synchronous) clears the count and the output valid flag;
// the cell contents are not cleared, since only written entries can be read.

module indexed_insert_erase_array_core
  import iiea_pkg::*;
#(
  parameter int CAPACITY = DEF_CAPACITY
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [39:0] in_tdata,   // [6:0] position, [38:7] value, [39] zero
  input  wire logic [2:0]  in_tuser,   // [2:0] command
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic      [39:0] out_tdata,  // [31:0] read_value, [38:32] count, [39] zero
  output logic      [1:0]  out_tuser   // [1:0] status
);

  // Width of the count, and a common width wide enough for both count and position.
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int PW = (CW > POS_W) ? CW : POS_W;

  logic                 fire;
  cmd_t                 cmd;
  logic [PW-1:0]        pos_w;
  logic [PW-1:0]        cnt_w;
  logic [WORD_W-1:0]    value;
  logic                 full;

  logic [CW-1:0]        cnt_r;
  logic [CW-1:0]        cnt_nxt;

  cell_ctrl_t           ctrl;
  logic [PW-1:0]        op_idx;
  stat_t                stat;
  logic [WORD_W-1:0]    rd_val;
  logic [WORD_W-1:0]    rd_bus;

  logic                 out_valid_r;
  logic [WORD_W-1:0]    out_rd_r;
  stat_t                out_stat_r;
  logic [POS_W-1:0]     out_cnt_r;

  logic [WORD_W-1:0]    words    [CAPACITY];
  logic [WORD_W-1:0]    rd_words [CAPACITY];

  assign in_tready = !out_valid_r || out_tready;
  assign fire      = in_tvalid && in_tready;

  assign cmd   = cmd_t'(in_tuser);
  assign pos_w = PW'(in_tdata[POS_W-1:0]);
  assign value = in_tdata[POS_W +: WORD_W];
  assign cnt_w = PW'(cnt_r);
  assign full  = (cnt_w >= PW'(CAPACITY));

  // Command decode: picks the operation the row performs and the outcome.
  // Nothing in the row moves unless a command is actually transferred.
  always_comb begin
    ctrl.op    = CELL_HOLD;
    ctrl.value = value;
    op_idx     = pos_w;
    stat       = ST_OK;
    rd_val     = '0;
    cnt_nxt    = cnt_r;
    unique case (cmd)
      CMD_APPEND: begin
        if (full) begin
          stat = ST_FULL;
        end else begin
          ctrl.op = CELL_WRITE;
          op_idx  = cnt_w;
          cnt_nxt = CW'(cnt_w + PW'(1));
        end
      end
      CMD_INSERT: begin
        if (pos_w > cnt_w) begin
          stat = ST_RANGE;
        end else if (full) begin
          stat = ST_FULL;
        end else begin
          ctrl.op = CELL_SHIFT_UP;
          cnt_nxt = CW'(cnt_w + PW'(1));
        end
      end
      CMD_ERASE: begin
        if (pos_w >= cnt_w) begin
          stat = ST_RANGE;
        end else begin
          ctrl.op = CELL_SHIFT_DOWN;
          cnt_nxt = CW'(cnt_w - PW'(1));
        end
      end
      CMD_CLEAR: begin
        cnt_nxt = '0;
      end
      CMD_READ: begin
        if (pos_w >= cnt_w) begin
          stat = ST_RANGE;
        end else begin
          rd_val = rd_bus;
        end
      end
      CMD_WRITE: begin
        if (pos_w >= cnt_w) begin
          stat = ST_RANGE;
        end else begin
          ctrl.op = CELL_WRITE;
        end
      end
      default: begin
        // Unused command codes leave everything unchanged and report success.
        stat = ST_OK;
      end
    endcase
    if (!fire) begin
      ctrl.op = CELL_HOLD;
      cnt_nxt = cnt_r;
    end
  end

  // The row of cells. Each cell sees its lower and upper neighbor; the ends
  // see themselves, which only affects entries beyond the count.
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [WORD_W-1:0] left_word;
    logic [WORD_W-1:0] right_word;

    assign left_word  = (i == 0) ? words[i] : words[(i == 0) ? 0 : i - 1];
    assign right_word = (i == CAPACITY - 1) ? words[i]
                                            : words[(i == CAPACITY - 1) ? i : i + 1];

    iiea_cell #(
      .IDX (i),
      .PW  (PW)
    ) u_cell (
      .clk        (clk),
      .ctrl       (ctrl),
      .op_idx     (op_idx),
      .rd_idx     (pos_w),
      .left_word  (left_word),
      .right_word (right_word),
      .word       (words[i]),
      .rd_word    (rd_words[i])
    );
  end

  // Only the addressed cell drives a nonzero word, so the read is an OR of all cells.
  always_comb begin
    rd_bus = '0;
    for (int k = 0; k < CAPACITY; k++) begin
      rd_bus = rd_bus | rd_words[k];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      if (fire) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Result payload; the count is reported on seven bits and wraps above that.
  always_ff @(posedge clk) begin
    if (fire) begin
      out_rd_r   <= rd_val;
      out_stat_r <= stat;
      out_cnt_r  <= POS_W'(PW'(cnt_nxt));
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, out_cnt_r, out_rd_r};
  assign out_tuser  = out_stat_r;

endmodule

`default_nettype wire

/* tb/indexed_insert_erase_array_core_tb.sv */
`timescale 1ns / 100ps

module indexed_insert_erase_array_core_tb;
  import iiea_pkg::*;

  localparam int CAPACITY = DEF_CAPACITY;

  // Command codes that the block treats as no-ops.
  localparam logic [CMD_W-1:0] CMD_SPARE_LO = 3'd6;
  localparam logic [CMD_W-1:0] CMD_SPARE_HI = 3'd7;

  // One result as the block should report it.
  typedef struct packed {
    logic [WORD_W-1:0] read_value;
    stat_t             status;
    logic [POS_W-1:0]  count;
  } array_result_t;

  // Shadow copy of the array. Every accepted command is applied here in order, and the
  // result it must produce is queued until the matching output transfer shows up.
  class array_tracker;
    logic [WORD_W-1:0] words[CAPACITY];
    int                fill;
    array_result_t     expected_results[$];
    int                mismatches;

    function new();
      fill       = 0;
      mismatches = 0;
      foreach (words[i]) words[i] = '0;
    endfunction

    function int pending();
      return expected_results.size();
    endfunction

    // Applies one accepted command to the shadow array and queues its result.
    function void note_command(cmd_t cmd, logic [POS_W-1:0] pos, logic [WORD_W-1:0] val);
      array_result_t r;
      int            p;
      p = int'(pos);
      r.read_value = '0;
      r.status     = ST_OK;
      case (cmd)
        CMD_APPEND: begin
          if (fill >= CAPACITY) begin
            r.status = ST_FULL;
          end else begin
            words[fill] = val;
            fill++;
          end
        end
        CMD_INSERT: begin
          // The position check takes precedence over the full check.
          if (p > fill) begin
            r.status = ST_RANGE;
          end else if (fill >= CAPACITY) begin
            r.status = ST_FULL;
          end else begin
            for (int i = fill; i > p; i--) words[i] = words[i-1];
            words[p] = val;
            fill++;
          end
        end
        CMD_ERASE: begin
          if (p >= fill) begin
            r.status = ST_RANGE;
          end else begin
            for (int i = p; i + 1 < fill; i++) words[i] = words[i+1];
            fill--;
          end
        end
        CMD_CLEAR: fill = 0;
        CMD_READ: begin
          if (p >= fill) r.status = ST_RANGE;
          else r.read_value = words[p];
        end
        CMD_WRITE: begin
          if (p >= fill) r.status = ST_RANGE;
          else words[p] = val;
        end
        default: ;
      endcase
      r.count = fill[POS_W-1:0];
      expected_results = {expected_results, r};
    endfunction

    function void report(string field, logic [WORD_W-1:0] want, logic [WORD_W-1:0] got);
      mismatches++;
      $display("%0t: %s mismatch: expected %h, actual %h", $time, field, want, got);
    endfunction

    // Compares one accepted result with the oldest expectation, field by field.
    function void check_result(logic [WORD_W-1:0] rd, logic [STAT_W-1:0] st,
                               logic [POS_W-1:0] cnt);
      array_result_t want;
      if (expected_results.size() == 0) begin
        report("unexpected result", '0, {rd[22:0], cnt, st});
        return;
      end
      want = expected_results.pop_front();
      if (rd !== want.read_value) report("read_value", want.read_value, rd);
      if (st !== want.status) report("status", 32'(want.status), 32'(st));
      if (cnt !== want.count) report("count", 32'(want.count), 32'(cnt));
    endfunction
  endclass

  logic              clk;
  logic              rst_n      = 1'b0;
  logic              in_tvalid  = 1'b0;
  logic              in_tready;
  logic [39:0]       in_tdata   = '0;  // [6:0] position, [38:7] value, [39] zero
  logic [CMD_W-1:0]  in_tuser   = '0;  // [2:0] command
  logic              out_tvalid;
  logic              out_tready = 1'b0;
  logic [39:0]       out_tdata;        // [31:0] read_value, [38:32] count, [39] zero
  logic [STAT_W-1:0] out_tuser;        // [1:0] status

  // Percentages of cycles in which the sender holds back and the receiver stalls.
  int idle_pct  = 0;
  int stall_pct = 0;

  array_tracker shadow = new();

  indexed_insert_erase_array_core #(
    .CAPACITY(CAPACITY)
  ) i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // The receiver drops out_tready at random according to the current stall rate.
  always @(posedge clk) begin
    out_tready <= ($urandom_range(0, 99) >= stall_pct);
  end

  // Both channels are observed at the clock edge, where every signal still holds the
  // value it had before the edge. The result is checked before the new command is noted,
  // although a command and its own result never transfer at the same edge.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready)
      shadow.check_result(out_tdata[31:0], out_tuser, out_tdata[38:32]);
    if (rst_n && in_tvalid && in_tready)
      shadow.note_command(cmd_t'(in_tuser), in_tdata[6:0], in_tdata[38:7]);
  end

  // Presents one command after a random gap and returns at the edge of its transfer.
  // in_tvalid stays high afterward, so back-to-back commands follow without a gap.
  task automatic send(input logic [CMD_W-1:0] cmd, input logic [POS_W-1:0] pos,
                      input logic [WORD_W-1:0] val);
    while ($urandom_range(0, 99) < idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {1'b0, val, pos};
    in_tuser  <= cmd;
    do @(posedge clk); while (!in_tready);
  endtask

  // Holds the input off until every queued result has been returned.
  task automatic drain_results();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (shadow.pending() != 0) @(posedge clk);
  endtask

  // Random word with a bias toward the extremes of the signed range.
  function automatic logic [WORD_W-1:0] pick_word();
    case ($urandom_range(0, 9))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'hFFFF_FFFF;
      3: return 32'h0000_0000;
      default: return $urandom;
    endcase
  endfunction

  // Mostly positions near or inside the live part of the array, which is where
  // insert, erase, read and write do real work. The rest spans the whole field.
  function automatic logic [POS_W-1:0] pick_position();
    int n;
    int r;
    n = shadow.fill;
    r = $urandom_range(0, 99);
    if (r < 55) return POS_W'($urandom_range(0, n));
    if (r < 70) return POS_W'((n == 0) ? 0 : n - 1);
    if (r < 80) return POS_W'(n);
    return POS_W'($urandom_range(0, 127));
  endfunction

  // One random command. A growing mix favors append and insert so that the array
  // reaches capacity; a shrinking mix favors erase so that it runs empty again.
  task automatic random_command(input bit grow);
    int               r;
    logic [CMD_W-1:0] cmd;
    r = $urandom_range(0, 199);
    if (grow) begin
      if (r < 70) cmd = CMD_APPEND;
      else if (r < 130) cmd = CMD_INSERT;
      else if (r < 150) cmd = CMD_ERASE;
      else if (r < 175) cmd = CMD_READ;
      else if (r < 192) cmd = CMD_WRITE;
      else if (r < 199) cmd = r[0] ? CMD_SPARE_HI : CMD_SPARE_LO;
      else cmd = CMD_CLEAR;
    end else begin
      if (r < 20) cmd = CMD_APPEND;
      else if (r < 40) cmd = CMD_INSERT;
      else if (r < 120) cmd = CMD_ERASE;
      else if (r < 150) cmd = CMD_READ;
      else if (r < 175) cmd = CMD_WRITE;
      else if (r < 195) cmd = r[0] ? CMD_SPARE_HI : CMD_SPARE_LO;
      else cmd = CMD_CLEAR;
    end
    send(cmd, pick_position(), pick_word());
  endtask

  // A stretch of random traffic under one idling setting. The growth direction flips
  // after random run lengths so the array swings between empty and full.
  task automatic random_phase(input int n, input int idle, input int stall);
    bit grow;
    int left;
    idle_pct  = idle;
    stall_pct = stall;
    grow      = 1'b1;
    left      = $urandom_range(60, 140);
    for (int k = 0; k < n; k++) begin
      random_command(grow);
      left--;
      if (left == 0) begin
        grow = !grow;
        left = $urandom_range(60, 140);
      end
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part: every command on the empty array, the extreme words, insert at
    // the front and at the end, out-of-range positions including the largest one,
    // the spare command codes, and erase at both ends.
    send(CMD_READ,     7'd0,   32'h0);
    send(CMD_ERASE,    7'd0,   32'h0);
    send(CMD_WRITE,    7'd0,   32'h1234_5678);
    send(CMD_INSERT,   7'd1,   32'h1);
    send(CMD_SPARE_LO, 7'd127, 32'hFFFF_FFFF);
    send(CMD_SPARE_HI, 7'd0,   32'h0);
    send(CMD_CLEAR,    7'd0,   32'h0);
    send(CMD_APPEND,   7'd0,   32'h7FFF_FFFF);
    send(CMD_APPEND,   7'd127, 32'h8000_0000);
    send(CMD_INSERT,   7'd0,   32'hFFFF_FFFF);
    send(CMD_INSERT,   7'd3,   32'h0);
    send(CMD_INSERT,   7'd5,   32'hDEAD_BEEF);
    send(CMD_INSERT,   7'd127, 32'hDEAD_BEEF);
    send(CMD_READ,     7'd0,   32'h0);
    send(CMD_READ,     7'd1,   32'h0);
    send(CMD_READ,     7'd2,   32'h0);
    send(CMD_READ,     7'd3,   32'h0);
    send(CMD_READ,     7'd4,   32'h0);
    send(CMD_READ,     7'd127, 32'h0);
    send(CMD_WRITE,    7'd3,   32'h5A5A_A5A5);
    send(CMD_WRITE,    7'd4,   32'h1);
    send(CMD_ERASE,    7'd3,   32'h0);
    send(CMD_ERASE,    7'd0,   32'h0);
    send(CMD_ERASE,    7'd5,   32'h0);
    send(CMD_READ,     7'd0,   32'h0);
    send(CMD_CLEAR,    7'd0,   32'h0);

    // Fill to capacity with random words, then try to grow past it: append and a
    // valid insert must report full, while an insert past the end reports a range
    // error even on the full array.
    for (int k = 0; k < CAPACITY + 2; k++) send(CMD_APPEND, POS_W'($urandom), pick_word());
    send(CMD_INSERT, 7'd0, pick_word());
    send(CMD_INSERT, POS_W'(CAPACITY), pick_word());
    send(CMD_INSERT, POS_W'(CAPACITY + 1), pick_word());
    send(CMD_READ,   POS_W'(CAPACITY - 1), 32'h0);
    send(CMD_READ,   POS_W'(CAPACITY), 32'h0);
    send(CMD_ERASE,  POS_W'(CAPACITY - 1), 32'h0);

    // Random part, one stretch per idling setting. The sender waits for the array to
    // go quiet between stretches.
    random_phase(280, 0, 0);
    drain_results();
    random_phase(230, 81, 0);
    drain_results();
    random_phase(230, 0, 81);
    drain_results();
    random_phase(260, 16, 16);
    drain_results();

    // All results are in; let the clock run on before finishing so that any stray
    // transfer shows.
    repeat (4) @(posedge clk);
    if (shadow.mismatches == 0 && shadow.pending() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // Watchdog: a correct run finishes far sooner, even with the heaviest stalling.
  initial begin
    #5_000_000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule

/* files.f */
rtl/core/iiea_pkg.sv
rtl/core/iiea_cell.sv
rtl/core/indexed_insert_erase_array_core.sv
tb/indexed_insert_erase_array_core_tb.sv
